### rtl/swhr_pkg.sv
// Shared types, constants and codes for the square window height range block.
// Used by the top level, swhr_minmax and swhr_ctrl; depends on nothing.
package swhr_pkg;

  localparam int MAX_GRID    = 64;
  localparam int HEIGHT_BITS = 16;
  localparam int IN_HEIGHT_W = 16;
  localparam int STORE_W     = (HEIGHT_BITS < IN_HEIGHT_W) ? HEIGHT_BITS : IN_HEIGHT_W;
  localparam int IDX_W       = $clog2(MAX_GRID);
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int RANGE_W     = 16;
  localparam int IN_DATA_W   = ((2 * IDX_W + IN_HEIGHT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((RANGE_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b1;

  localparam logic [CFG_W-1:0] GRID_SIZE_RST   = CFG_W'(64);
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(1);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic clr;
    logic smp;
  } acc_ctl_t;

endpackage

### rtl/square_window_height_range.sv
// Top level of the square window height range block: stream ports, configuration
// registers, height store, sequencer and shared compare unit.
// Depends on swhr_pkg, swhr_ram, swhr_minmax and swhr_ctrl.
//
// A load item writes one cell of a 64 x 64 store of signed heights. A query item
// returns the largest minus the smallest height in the square window whose
// top-left cell it names; the window is read through the single read port of the
// store, one cell per cycle, into one shared max/min compare unit. A window that
// leaves the grid in use, or a window size of zero, returns a zero range with
// window_outside set. No item is accepted while a query is at work; a finished
// result waits in an output register, so a new item may be taken before it is
// collected. Reading a cell never loaded since reset gives an undefined height.
module square_window_height_range
  import swhr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // row_index, column_index, cell_height
  input  logic                  s_axis_tuser,   // operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // height_range
  output logic                  m_axis_tuser    // window_outside
);

  logic [CFG_W-1:0]          grid_size_q, grid_size_d;
  logic [CFG_W-1:0]          window_size_q, window_size_d;
  op_e                       op;
  logic [IDX_W-1:0]          row_in;
  logic [IDX_W-1:0]          col_in;
  logic [IN_HEIGHT_W-1:0]    height_in;
  logic                      wr_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic [STORE_W-1:0]        rd_data;
  acc_ctl_t                  acc_ctl;
  logic [RANGE_W-1:0]        range;
  logic [RANGE_W-1:0]        out_range;

  always_comb begin
    grid_size_d   = grid_size_q;
    window_size_d = window_size_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_SIZE:   grid_size_d   = cfg_data_i;
        REG_WINDOW_SIZE: window_size_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q   <= GRID_SIZE_RST;
      window_size_q <= WINDOW_SIZE_RST;
    end else begin
      grid_size_q   <= grid_size_d;
      window_size_q <= window_size_d;
    end
  end

  assign op        = op_e'(s_axis_tuser);
  assign row_in    = s_axis_tdata[IDX_W-1:0];
  assign col_in    = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign height_in = s_axis_tdata[2*IDX_W+IN_HEIGHT_W-1:2*IDX_W];
  assign wr_en     = s_axis_tvalid && s_axis_tready && (op == OP_LOAD);

  swhr_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (STORE_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i ({row_in, col_in}),
    .wr_data_i (height_in[STORE_W-1:0]),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  swhr_minmax u_minmax (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (acc_ctl),
    .height_i (rd_data),
    .range_o  (range)
  );

  swhr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .op_i          (op),
    .row_i         (row_in),
    .col_i         (col_in),
    .grid_size_i   (grid_size_q),
    .window_size_i (window_size_q),
    .rd_addr_o     (rd_addr),
    .acc_o         (acc_ctl),
    .range_i       (range),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_range_o   (out_range),
    .out_outside_o (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_DATA_W'(out_range);

endmodule

### rtl/swhr_ram.sv
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module swhr_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

### rtl/swhr_minmax.sv
// Shared compare unit: running maximum and minimum of the sampled heights,
// and their saturated difference. Depends on swhr_pkg.
module swhr_minmax
  import swhr_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  acc_ctl_t                  ctl_i,
  input  logic signed [STORE_W-1:0] height_i,
  output logic [RANGE_W-1:0]        range_o
);

  localparam int DIFF_W = STORE_W + 1;
  localparam int WIDE_W = RANGE_W + DIFF_W;
  localparam logic [WIDE_W-1:0] RANGE_MAX = {{DIFF_W{1'b0}}, {RANGE_W{1'b1}}};

  logic                      empty_q, empty_d;
  logic signed [STORE_W-1:0] hi_q, hi_d;
  logic signed [STORE_W-1:0] lo_q, lo_d;
  logic [DIFF_W-1:0]         diff;
  logic [WIDE_W-1:0]         diff_w;

  always_comb begin
    empty_d = empty_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    if (ctl_i.clr) begin
      empty_d = 1'b1;
    end else if (ctl_i.smp) begin
      empty_d = 1'b0;
      if (empty_q || height_i > hi_q) begin
        hi_d = height_i;
      end
      if (empty_q || height_i < lo_q) begin
        lo_d = height_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b1;
    end else begin
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  always_comb begin
    diff    = {hi_q[STORE_W-1], hi_q} - {lo_q[STORE_W-1], lo_q};
    diff_w  = WIDE_W'(diff);
    range_o = (diff_w > RANGE_MAX) ? RANGE_W'(RANGE_MAX) : diff_w[RANGE_W-1:0];
  end

endmodule

### rtl/swhr_ctrl.sv
// Sequencer: accepts items, checks the window against the grid, walks the
// window addresses and holds the result register. Depends on swhr_pkg.
module swhr_ctrl
  import swhr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  op_e                op_i,
  input  logic [IDX_W-1:0]   row_i,
  input  logic [IDX_W-1:0]   col_i,
  input  logic [CFG_W-1:0]   grid_size_i,
  input  logic [CFG_W-1:0]   window_size_i,
  output logic [ADDR_W-1:0]  rd_addr_o,
  output acc_ctl_t           acc_o,
  input  logic [RANGE_W-1:0] range_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RANGE_W-1:0] out_range_o,
  output logic               out_outside_o
);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   row_q, row_d;
  logic [IDX_W-1:0]   col_q, col_d;
  logic [IDX_W-1:0]   col_first_q, col_first_d;
  logic [IDX_W-1:0]   row_last_q, row_last_d;
  logic [IDX_W-1:0]   col_last_q, col_last_d;
  logic               outside_q, outside_d;
  logic               smp_q;
  logic               out_valid_q, out_valid_d;
  logic [RANGE_W-1:0] out_range_q, out_range_d;
  logic               out_outside_q, out_outside_d;

  logic               query_fire;
  logic               walk_end;
  logic               issue;
  logic               out_load;
  logic [CFG_W-1:0]   grid_eff;
  logic [CFG_W:0]     row_end;
  logic [CFG_W:0]     col_end;
  logic               outside_now;

  always_comb begin
    grid_eff = (grid_size_i > CFG_W'(MAX_GRID)) ? CFG_W'(MAX_GRID) : grid_size_i;
    row_end  = (CFG_W + 1)'(row_i) + (CFG_W + 1)'(window_size_i);
    col_end  = (CFG_W + 1)'(col_i) + (CFG_W + 1)'(window_size_i);
    outside_now = (window_size_i == '0) || (row_end > (CFG_W + 1)'(grid_eff)) ||
                  (col_end > (CFG_W + 1)'(grid_eff));
  end

  assign query_fire = in_valid_i && in_ready_o && (op_i == OP_QUERY);
  assign walk_end   = (row_q == row_last_q) && (col_q == col_last_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (query_fire) begin
          state_d = outside_now ? ST_RESULT : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_WALK:   issue      = 1'b1;
      ST_DRAIN:  ;
      ST_RESULT: out_load   = !out_valid_q || out_ready_i;
      default:   ;
    endcase
  end

  assign rd_addr_o = {row_q, col_q};
  assign acc_o     = '{clr: query_fire, smp: smp_q};

  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    col_first_d = col_first_q;
    row_last_d  = row_last_q;
    col_last_d  = col_last_q;
    outside_d   = outside_q;
    if (query_fire) begin
      row_d       = row_i;
      col_d       = col_i;
      col_first_d = col_i;
      row_last_d  = IDX_W'(row_end - (CFG_W + 1)'(1));
      col_last_d  = IDX_W'(col_end - (CFG_W + 1)'(1));
      outside_d   = outside_now;
    end else if (issue) begin
      if (col_q == col_last_q) begin
        col_d = col_first_q;
        row_d = row_q + IDX_W'(1);
      end else begin
        col_d = col_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_d   = out_valid_q;
    out_range_d   = out_range_q;
    out_outside_d = out_outside_q;
    if (out_load) begin
      out_valid_d   = 1'b1;
      out_range_d   = outside_q ? '0 : range_i;
      out_outside_d = outside_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      smp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      smp_q       <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q         <= row_d;
    col_q         <= col_d;
    col_first_q   <= col_first_d;
    row_last_q    <= row_last_d;
    col_last_q    <= col_last_d;
    outside_q     <= outside_d;
    out_range_q   <= out_range_d;
    out_outside_q <= out_outside_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_range_o   = out_range_q;
  assign out_outside_o = out_outside_q;

endmodule

### tb/sv/tb_top.sv
// Self-checking bench for square_window_height_range: loads cells, queries window ranges
// under several grid and window settings, and checks every result against its own model.
// Depends on swhr_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 100ps

module tb_top;
  import swhr_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPORT_LIMIT  = 50;
  localparam int QUERY_SPREAD  = 2;

  typedef struct {
    op_e                 op;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic signed [15:0]  height;
  } cell_item_t;

  typedef struct {
    logic [RANGE_W-1:0] span;
    logic               outside;
  } window_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // row_index, column_index, cell_height
  logic                  s_axis_tuser = 1'b0; // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // height_range
  logic                  m_axis_tuser;        // window_outside

  cell_item_t         pending_items[$];
  window_result_t     expected_spans[$];
  logic signed [15:0] height_grid[MAX_GRID][MAX_GRID];
  bit                 gen_loaded[MAX_GRID][MAX_GRID];
  logic [CFG_W-1:0]   grid_cfg = GRID_SIZE_RST;
  logic [CFG_W-1:0]   win_cfg = WINDOW_SIZE_RST;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  int unsigned        hold_requests = 0;
  int unsigned        hold_seen = 0;
  int unsigned        hold_left = 0;
  int unsigned        mismatch_count = 0;

  square_window_height_range DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic int used_grid();
    return (grid_cfg > MAX_GRID) ? MAX_GRID : int'(grid_cfg);
  endfunction

  function automatic logic signed [15:0] pick_height();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
  endtask

  // Track one accepted item: store a load, or work out the range of a query window.
  task automatic predict_window(cell_item_t it);
    window_result_t res;
    int gg, ws, hi, lo, span;
    if (it.op == OP_LOAD) begin
      height_grid[it.row][it.col] = it.height;
    end else begin
      gg = used_grid();
      ws = int'(win_cfg);
      res.span = '0;
      res.outside = 1'b1;
      if (ws != 0 && int'(it.row) + ws <= gg && int'(it.col) + ws <= gg) begin
        hi = -32769;
        lo = 32768;
        for (int r = int'(it.row); r < int'(it.row) + ws; r++) begin
          for (int c = int'(it.col); c < int'(it.col) + ws; c++) begin
            if (int'(height_grid[r][c]) > hi) hi = int'(height_grid[r][c]);
            if (int'(height_grid[r][c]) < lo) lo = int'(height_grid[r][c]);
          end
        end
        span = hi - lo;
        if (span > 65535) span = 65535;
        res.span = RANGE_W'(span);
        res.outside = 1'b0;
      end
      expected_spans.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_item_t taken;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        taken = pending_items.pop_front();
        predict_window(taken);
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the item on offer
      end else if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({pending_items[0].height, pending_items[0].col,
                                     pending_items[0].row});
        s_axis_tuser  <= pending_items[0].op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    window_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_spans.size() == 0) begin
          report_mismatch($sformatf("unexpected result: range %0d outside %0b",
                                    m_axis_tdata[RANGE_W-1:0], m_axis_tuser));
        end else begin
          want = expected_spans.pop_front();
          if (m_axis_tdata[RANGE_W-1:0] !== want.span) begin
            report_mismatch($sformatf("height_range %0d, want %0d",
                                      m_axis_tdata[RANGE_W-1:0], want.span));
          end
          if (m_axis_tuser !== want.outside) begin
            report_mismatch($sformatf("window_outside %0b, want %0b",
                                      m_axis_tuser, want.outside));
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_load(int r, int c, logic signed [15:0] h);
    cell_item_t it;
    it.op = OP_LOAD;
    it.row = IDX_W'(r);
    it.col = IDX_W'(c);
    it.height = h;
    pending_items.push_back(it);
    gen_loaded[r][c] = 1'b1;
  endtask

  // Queue a query, first loading any cell of the window not yet written, so no query reads an undefined height.
  task automatic push_query(int r, int c);
    cell_item_t it;
    int gg, ws;
    gg = used_grid();
    ws = int'(win_cfg);
    if (ws != 0 && r + ws <= gg && c + ws <= gg) begin
      for (int rr = r; rr < r + ws; rr++) begin
        for (int cc = c; cc < c + ws; cc++) begin
          if (!gen_loaded[rr][cc]) push_load(rr, cc, pick_height());
        end
      end
    end
    it.op = OP_QUERY;
    it.row = IDX_W'(r);
    it.col = IDX_W'(c);
    it.height = pick_height();
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_spans.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == REG_GRID_SIZE) grid_cfg = val;
    else win_cfg = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int g, int ws);
    drain();
    write_reg(REG_GRID_SIZE, CFG_W'(g));
    write_reg(REG_WINDOW_SIZE, CFG_W'(ws));
  endtask

  // Keep in-grid corners in a small patch so windows share loaded cells; put the
  // left column of other queries far enough right that the window crosses the grid edge wherever the grid allows it.
  task automatic run_phase(int g, int ws, int n, int unsigned send_pct,
                           int unsigned recv_pct, bit hold);
    int gg, base_r, base_c, last_r, last_c, past_c;
    set_config(g, ws);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    gg = used_grid();
    base_r = 0;
    base_c = 0;
    last_r = 0;
    last_c = 0;
    if (ws != 0 && ws <= gg) begin
      base_r = $urandom_range(gg - ws);
      base_c = $urandom_range(gg - ws);
      last_r = (base_r + QUERY_SPREAD < gg - ws) ? base_r + QUERY_SPREAD : gg - ws;
      last_c = (base_c + QUERY_SPREAD < gg - ws) ? base_c + QUERY_SPREAD : gg - ws;
    end
    past_c = gg - ws + 1;
    if (ws == 0 || ws > gg || past_c > MAX_GRID - 1) past_c = 0;
    if (hold) begin
      @(posedge clk_i);
      hold_requests <= hold_requests + 1;
    end
    repeat (n) begin
      if ($urandom_range(99) < 35) begin
        push_load($urandom_range(MAX_GRID - 1), $urandom_range(MAX_GRID - 1), pick_height());
      end else if ($urandom_range(99) < 75 && ws != 0 && ws <= gg) begin
        push_query($urandom_range(last_r, base_r), $urandom_range(last_c, base_c));
      end else begin
        push_query($urandom_range(MAX_GRID - 1), $urandom_range(MAX_GRID - 1, past_c));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(64, 1);
    push_load(0, 0, 16'sh7fff);
    push_load(0, 1, 16'sh8000);
    push_load(1, 0, 16'sh0000);
    push_load(1, 1, -16'sd1);
    push_load(63, 63, 16'sh8000);
    push_query(0, 0);
    push_query(63, 63);
    push_query(0, 1);
    set_config(64, 2);
    push_query(0, 0);
    push_query(63, 63);
    push_query(62, 62);
    set_config(127, 1);
    push_query(63, 63);
    set_config(0, 1);
    push_query(0, 0);
    set_config(64, 0);
    push_query(0, 0);
    set_config(2, 2);
    push_query(0, 0);
    push_query(0, 1);
    push_query(1, 0);

    run_phase(64, 1, 30, 0, 0, 1'b0);
    run_phase(64, 3, 30, 85, 0, 1'b0);
    run_phase(16, 4, 30, 0, 85, 1'b0);
    run_phase(7, 2, 30, 38, 38, 1'b0);
    run_phase(0, 3, 15, 85, 0, 1'b0);
    run_phase(127, 5, 35, 0, 0, 1'b1);
    run_phase(64, 0, 15, 0, 85, 1'b0);
    run_phase(33, 127, 15, 38, 38, 1'b0);
    run_phase(64, 6, 25, 0, 0, 1'b0);
    run_phase(2, 2, 20, 0, 85, 1'b0);
    run_phase(40, 8, 15, 38, 38, 1'b0);
    run_phase(6, 6, 6, 0, 0, 1'b0);
    run_phase(64, 2, 30, 38, 38, 1'b0);
    run_phase(64, 1, 30, 85, 0, 1'b0);
    drain();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
